@@ rtl/mmrc_pkg.sv @@
// Shared types and constants for the Modbus master request/response check unit.
// No dependencies; used by every module under rtl/.
`default_nettype none

package mmrc_pkg;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 32;
    localparam int TX_MAX    = 7;

    // operation codes (tuser on the input side)
    localparam logic OP_REQUEST  = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    // result kind (tuser on the output side)
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Modbus function codes handled here
    localparam logic [7:0] FN_READ_COILS     = 8'd1;
    localparam logic [7:0] FN_READ_INPUTS    = 8'd2;
    localparam logic [7:0] FN_READ_HOLDING   = 8'd3;
    localparam logic [7:0] FN_READ_INPUT_REG = 8'd4;
    localparam logic [7:0] FN_WRITE_COIL     = 8'd5;
    localparam logic [7:0] FN_WRITE_REG      = 8'd6;
    localparam logic [7:0] FN_READ_EXC_STAT  = 8'd7;
    localparam logic [7:0] FN_DIAGNOSTICS    = 8'd8;
    localparam logic [7:0] FN_WRITE_COILS    = 8'd15;
    localparam logic [7:0] FN_MASK_WRITE     = 8'd22;

    localparam logic [7:0] EXC_FLAG    = 8'h80;
    localparam logic [7:0] COIL_ON_HI  = 8'hFF;
    localparam logic [7:0] COIL_OFF_HI = 8'h00;

    localparam logic [15:0] MAX_COILS      = 16'd2000;
    localparam logic [15:0] MAX_REGS       = 16'd125;
    localparam logic [15:0] MAX_WR_COILS   = 16'd1968;
    localparam logic [15:0] DIAG_SUB_MAX   = 16'd20;
    localparam logic [15:0] DIAG_GAP_LO    = 16'd4;
    localparam logic [15:0] DIAG_GAP_HI    = 16'd10;

    localparam logic [7:0] CAP_RESET = 8'd253;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_EXCEPTION   = 4'd1,
        ST_BAD_FUNC    = 4'd2,
        ST_BAD_LENGTH  = 4'd3,
        ST_BAD_ADDRESS = 4'd4,
        ST_BAD_DATA    = 4'd5,
        ST_BAD_SUBFUNC = 4'd6,
        ST_UNSUPPORTED = 4'd7,
        ST_TOO_FEW     = 4'd8,
        ST_TOO_MANY    = 4'd9,
        ST_BUF_SMALL   = 4'd10
    } status_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  function_req;
        logic [15:0] address;
        logic [15:0] quantity_or_value;
        logic [15:0] diag_sub;
        logic [15:0] and_mask;
        logic [15:0] or_mask;
        logic        coil_on;
        logic [7:0]  rx_byte;
        logic        rx_last;
    } in_item_t;

    // one or more results caused by one item: either a run of tx bytes or one status
    typedef struct packed {
        logic                     is_status;
        logic [2:0]               count;
        logic [TX_MAX-1:0][7:0]   bytes;
        status_t                  status;
        logic [7:0]               exception_code;
        logic [1:0]               data_offset;
        logic [7:0]               data_length;
    } batch_t;

endpackage

`default_nettype wire

@@ rtl/mmrc_engine.sv @@
// Request limit checks, header build and response header compare.
// Holds the PDU capacity register and the header state. Uses mmrc_pkg.
`default_nettype none

module mmrc_engine #(
    parameter int HEAD_BYTES = 7
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_wdata,
    input  wire mmrc_pkg::in_item_t item,
    input  wire logic              commit,
    output mmrc_pkg::batch_t       batch,
    output logic                   has_result
);

    logic [7:0]  cap_reg;
    logic [HEAD_BYTES-1:0][7:0] exp_head_reg;
    logic [HEAD_BYTES-1:0][7:0] rcv_head_reg;
    logic [HEAD_BYTES-1:0][7:0] rcv_head_next;
    logic [7:0]  rx_index_reg;
    logic [7:0]  rx_index_inc;
    mmrc_pkg::status_t pending_error_reg;

    // request side
    mmrc_pkg::status_t req_err;
    logic [2:0]  req_n;
    logic [6:0][7:0] tx;
    logic [6:0][7:0] ex;
    logic [16:0] bc_coil;
    logic [16:0] bc_read;
    logic [16:0] cap_w;

    // response side
    logic [6:0]  same_v;
    logic [7:0]  f;
    mmrc_pkg::status_t rsp_st;
    logic [7:0]  rsp_exc;
    logic [1:0]  rsp_off;
    logic [7:0]  rsp_len;

    assign bc_coil = (17'(item.quantity_or_value) + 17'd7) >> 3;
    assign bc_read = {item.quantity_or_value, 1'b0};
    assign cap_w   = 17'(cap_reg);

    always_comb
    begin
        req_err = mmrc_pkg::ST_OK;
        req_n   = 3'd0;
        tx      = '0;
        ex      = '0;
        tx[0]   = item.function_req;
        ex[0]   = item.function_req;
        tx[1]   = item.address[15:8];
        tx[2]   = item.address[7:0];
        case (item.function_req)
            mmrc_pkg::FN_READ_COILS, mmrc_pkg::FN_READ_INPUTS,
            mmrc_pkg::FN_READ_HOLDING, mmrc_pkg::FN_READ_INPUT_REG:
            begin
                if (item.quantity_or_value == 16'd0)
                begin
                    req_err = mmrc_pkg::ST_TOO_FEW;
                end
                else if (item.function_req <= mmrc_pkg::FN_READ_INPUTS)
                begin
                    if (item.quantity_or_value > mmrc_pkg::MAX_COILS)
                        req_err = mmrc_pkg::ST_TOO_MANY;
                    else if (cap_reg < 8'd5 || cap_w < 17'd2 + bc_coil)
                        req_err = mmrc_pkg::ST_BUF_SMALL;
                    ex[1] = bc_coil[7:0];
                end
                else
                begin
                    if (item.quantity_or_value > mmrc_pkg::MAX_REGS)
                        req_err = mmrc_pkg::ST_TOO_MANY;
                    else if (cap_reg < 8'd5 || cap_w < 17'd2 + bc_read)
                        req_err = mmrc_pkg::ST_BUF_SMALL;
                    ex[1] = bc_read[7:0];
                end
                tx[3] = item.quantity_or_value[15:8];
                tx[4] = item.quantity_or_value[7:0];
                req_n = 3'd5;
            end
            mmrc_pkg::FN_WRITE_COIL, mmrc_pkg::FN_WRITE_REG, mmrc_pkg::FN_DIAGNOSTICS:
            begin
                if (item.function_req == mmrc_pkg::FN_DIAGNOSTICS &&
                    (item.diag_sub > mmrc_pkg::DIAG_SUB_MAX ||
                     (item.diag_sub > mmrc_pkg::DIAG_GAP_LO &&
                      item.diag_sub < mmrc_pkg::DIAG_GAP_HI)))
                    req_err = mmrc_pkg::ST_BAD_SUBFUNC;
                else if (cap_reg < 8'd5)
                    req_err = mmrc_pkg::ST_BUF_SMALL;
                tx[3] = item.quantity_or_value[15:8];
                tx[4] = item.quantity_or_value[7:0];
                if (item.function_req == mmrc_pkg::FN_WRITE_COIL)
                begin
                    tx[3] = item.coil_on ? mmrc_pkg::COIL_ON_HI : mmrc_pkg::COIL_OFF_HI;
                    tx[4] = 8'h00;
                end
                if (item.function_req == mmrc_pkg::FN_DIAGNOSTICS)
                begin
                    tx[1] = item.diag_sub[15:8];
                    tx[2] = item.diag_sub[7:0];
                end
                ex[4:1] = tx[4:1];
                req_n = 3'd5;
            end
            mmrc_pkg::FN_READ_EXC_STAT:
            begin
                if (cap_reg < 8'd2)
                    req_err = mmrc_pkg::ST_BUF_SMALL;
                req_n = 3'd1;
            end
            mmrc_pkg::FN_WRITE_COILS:
            begin
                if (item.quantity_or_value == 16'd0)
                    req_err = mmrc_pkg::ST_TOO_FEW;
                else if (item.quantity_or_value > mmrc_pkg::MAX_WR_COILS)
                    req_err = mmrc_pkg::ST_TOO_MANY;
                else if (cap_w < 17'd6 + bc_coil)
                    req_err = mmrc_pkg::ST_BUF_SMALL;
                tx[3] = item.quantity_or_value[15:8];
                tx[4] = item.quantity_or_value[7:0];
                tx[5] = bc_coil[7:0];
                ex[4:1] = tx[4:1];
                req_n = 3'd6;
            end
            mmrc_pkg::FN_MASK_WRITE:
            begin
                if (cap_reg < 8'd7)
                    req_err = mmrc_pkg::ST_BUF_SMALL;
                tx[3] = item.and_mask[15:8];
                tx[4] = item.and_mask[7:0];
                tx[5] = item.or_mask[15:8];
                tx[6] = item.or_mask[7:0];
                ex[6:1] = tx[6:1];
                req_n = 3'd7;
            end
            default:
            begin
                req_err = mmrc_pkg::ST_UNSUPPORTED;
            end
        endcase
    end

    // header with the incoming byte written in, then the compare
    assign rx_index_inc = (rx_index_reg == 8'hFF) ? rx_index_reg : rx_index_reg + 8'd1;

    always_comb
    begin
        for (int i = 0; i < HEAD_BYTES; i++)
        begin
            rcv_head_next[i] = (rx_index_reg == 8'(i)) ? item.rx_byte : rcv_head_reg[i];
        end
        for (int i = 0; i < 7; i++)
        begin
            same_v[i] = (i < HEAD_BYTES) && (8'(i) < rx_index_inc) &&
                        (rcv_head_next[i] == exp_head_reg[i]);
        end
    end

    assign f = rcv_head_next[0];

    always_comb
    begin
        rsp_st  = mmrc_pkg::ST_OK;
        rsp_exc = 8'd0;
        rsp_off = 2'd0;
        rsp_len = 8'd0;
        if (pending_error_reg != mmrc_pkg::ST_OK)
        begin
            rsp_st = pending_error_reg;
        end
        else if ({1'b0, f} == {1'b0, exp_head_reg[0]} + {1'b0, mmrc_pkg::EXC_FLAG})
        begin
            // rx_index_inc is at least 1 here, so byte 0 is present
            rsp_st  = mmrc_pkg::ST_EXCEPTION;
            rsp_exc = (rx_index_inc > 8'd1) ? rcv_head_next[1] : 8'd0;
        end
        else if (!same_v[0])
        begin
            rsp_st = mmrc_pkg::ST_BAD_FUNC;
        end
        else
        begin
            case (f)
                mmrc_pkg::FN_READ_COILS, mmrc_pkg::FN_READ_INPUTS,
                mmrc_pkg::FN_READ_HOLDING, mmrc_pkg::FN_READ_INPUT_REG:
                begin
                    if (!same_v[1])
                        rsp_st = mmrc_pkg::ST_BAD_LENGTH;
                    else
                    begin
                        rsp_off = 2'd2;
                        rsp_len = rcv_head_next[1];
                    end
                end
                mmrc_pkg::FN_WRITE_COIL, mmrc_pkg::FN_WRITE_REG:
                begin
                    if (!(same_v[1] && same_v[2]))
                        rsp_st = mmrc_pkg::ST_BAD_ADDRESS;
                    else if (!(same_v[3] && same_v[4]))
                        rsp_st = mmrc_pkg::ST_BAD_DATA;
                end
                mmrc_pkg::FN_READ_EXC_STAT:
                begin
                    rsp_off = 2'd1;
                    rsp_len = 8'd1;
                end
                mmrc_pkg::FN_DIAGNOSTICS:
                begin
                    if (!(same_v[1] && same_v[2]))
                        rsp_st = mmrc_pkg::ST_BAD_SUBFUNC;
                    else
                    begin
                        rsp_off = 2'd3;
                        rsp_len = 8'd2;
                    end
                end
                mmrc_pkg::FN_WRITE_COILS:
                begin
                    if (!(same_v[1] && same_v[2]))
                        rsp_st = mmrc_pkg::ST_BAD_ADDRESS;
                    else if (!(same_v[3] && same_v[4]))
                        rsp_st = mmrc_pkg::ST_BAD_LENGTH;
                end
                mmrc_pkg::FN_MASK_WRITE:
                begin
                    if (!(same_v[1] && same_v[2]))
                        rsp_st = mmrc_pkg::ST_BAD_ADDRESS;
                    else if (!(same_v[3] && same_v[4] && same_v[5] && same_v[6]))
                        rsp_st = mmrc_pkg::ST_BAD_DATA;
                end
                default:
                begin
                    rsp_st = mmrc_pkg::ST_UNSUPPORTED;
                end
            endcase
        end
    end

    always_comb
    begin
        batch = '0;
        if (item.op == mmrc_pkg::OP_REQUEST)
        begin
            has_result = 1'b1;
            if (req_err != mmrc_pkg::ST_OK)
            begin
                batch.is_status = mmrc_pkg::KIND_STATUS;
                batch.status    = req_err;
            end
            else
            begin
                batch.is_status = mmrc_pkg::KIND_TX;
                batch.count     = req_n;
                batch.bytes     = tx;
            end
        end
        else
        begin
            has_result            = item.rx_last;
            batch.is_status       = mmrc_pkg::KIND_STATUS;
            batch.status          = rsp_st;
            batch.exception_code  = rsp_exc;
            batch.data_offset     = rsp_off;
            batch.data_length     = rsp_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg           <= mmrc_pkg::CAP_RESET;
            exp_head_reg      <= '0;
            rcv_head_reg      <= '0;
            rx_index_reg      <= 8'd0;
            pending_error_reg <= mmrc_pkg::ST_OK;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (commit)
            begin
                if (item.op == mmrc_pkg::OP_REQUEST)
                begin
                    rx_index_reg      <= 8'd0;
                    pending_error_reg <= req_err;
                    if (req_err == mmrc_pkg::ST_OK)
                    begin
                        exp_head_reg <= '0;
                        for (int i = 0; i < 7; i++)
                        begin
                            if (i < HEAD_BYTES)
                                exp_head_reg[i] <= ex[i];
                        end
                        rcv_head_reg <= '0;
                    end
                end
                else
                begin
                    rcv_head_reg <= rcv_head_next;
                    if (item.rx_last)
                    begin
                        rx_index_reg      <= 8'd0;
                        pending_error_reg <= mmrc_pkg::ST_OK;
                    end
                    else
                    begin
                        rx_index_reg <= rx_index_inc;
                    end
                end
            end
        end
    end

    a_req_clears_index: assert property (@(posedge clk) disable iff (!rst_n)
        commit && item.op == mmrc_pkg::OP_REQUEST |=> rx_index_reg == 8'd0)
        else $error("rx index not cleared by request");

    a_completion_clears: assert property (@(posedge clk) disable iff (!rst_n)
        commit && item.op == mmrc_pkg::OP_RESPONSE && item.rx_last |=>
        rx_index_reg == 8'd0 && pending_error_reg == mmrc_pkg::ST_OK)
        else $error("completion left index or pending error set");

endmodule

`default_nettype wire

@@ rtl/mmrc_emitter.sv @@
// Output register: holds one batch of results and hands it out one result per accepted transfer.
// Drives the master-side stream. Uses mmrc_pkg.
`default_nettype none

module mmrc_emitter (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire mmrc_pkg::batch_t                    batch_in,
    output logic                                     free,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [mmrc_pkg::M_TDATA_W-1:0]           m_tdata,  // tx_byte, status, exception_code, data_offset, data_length
    output logic                                     m_tuser,  // kind
    output logic                                     m_tlast   // tx_last
);

    logic             busy_reg;
    mmrc_pkg::batch_t batch_reg;
    logic             take;
    logic             last_one;

    assign take     = busy_reg && m_tready;
    assign last_one = batch_reg.is_status || batch_reg.count == 3'd1;
    assign free     = !busy_reg || (take && last_one);

    assign m_tvalid = busy_reg;
    assign m_tuser  = batch_reg.is_status;
    assign m_tlast  = !batch_reg.is_status && batch_reg.count == 3'd1;
    assign m_tdata  = {2'b00, batch_reg.data_length, batch_reg.data_offset,
                       batch_reg.exception_code, batch_reg.status, batch_reg.bytes[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
        end
        else if (take && last_one)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            batch_reg <= batch_in;
        end
        else if (take && !last_one)
        begin
            // next tx byte moves to the front
            batch_reg.bytes <= {8'h00, batch_reg.bytes[mmrc_pkg::TX_MAX-1:1]};
            batch_reg.count <= batch_reg.count - 3'd1;
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("batch loaded over undelivered results");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !batch_reg.is_status |-> batch_reg.count != 3'd0)
        else $error("tx batch with no bytes");

endmodule

`default_nettype wire

@@ rtl/modbus_master_request_response_check_unit.sv @@
// An accepted request is registered, checked by mmrc_engine and loaded into the output register
// once the emitter is free. One item per cycle is taken while the output is not held; a request
// producing n tx bytes holds the output until all n are taken, and the input register stalls
// behind it. Response bytes without rx_last take no output slot.
// Reset (async, active low) clears header state, counters and valids; capacity returns to 253.
// Top level: input register, mmrc_engine and mmrc_emitter. Uses mmrc_pkg.
`default_nettype none

module modbus_master_request_response_check_unit #(
    parameter int HEAD_BYTES = 7
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [7:0]                        cfg_wdata,  // pdu_capacity
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // function_req, address, quantity_or_value, diag_sub, and_mask, or_mask, coil_on, rx_byte
    input  wire logic [mmrc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tuser,    // operation
    input  wire logic                              s_tlast,    // rx_last
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tx_byte, status, exception_code, data_offset, data_length
    output logic [mmrc_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tuser,    // kind
    output logic                                   m_tlast     // tx_last
);

    logic               in_valid_reg;
    mmrc_pkg::in_item_t in_reg;
    mmrc_pkg::batch_t   batch;
    logic               has_result;
    logic               emit_free;
    logic               commit;

    assign commit   = in_valid_reg && (!has_result || emit_free);
    assign s_tready = !in_valid_reg || commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (commit)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.op                <= s_tuser;
            in_reg.function_req      <= s_tdata[7:0];
            in_reg.address           <= s_tdata[23:8];
            in_reg.quantity_or_value <= s_tdata[39:24];
            in_reg.diag_sub          <= s_tdata[55:40];
            in_reg.and_mask          <= s_tdata[71:56];
            in_reg.or_mask           <= s_tdata[87:72];
            in_reg.coil_on           <= s_tdata[88];
            in_reg.rx_byte           <= s_tdata[96:89];
            in_reg.rx_last           <= s_tlast;
        end
    end

    mmrc_engine #(
        .HEAD_BYTES (HEAD_BYTES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item       (in_reg),
        .commit     (commit),
        .batch      (batch),
        .has_result (has_result)
    );

    mmrc_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (commit && has_result),
        .batch_in (batch),
        .free     (emit_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_commit_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> in_valid_reg)
        else $error("commit without a registered item");

endmodule

`default_nettype wire
